/* hw/rtl/ter_pkg.sv */
// ter_pkg: shared types and constants of the tcp echo responder
// request and reply descriptor layouts, action codes, tcp flag masks
// no dependencies
`timescale 1ns / 1ps

package ter_pkg;

  // reply action codes
  typedef enum logic [2:0] {
    ACT_DROP    = 3'd0,
    ACT_SYN_ACK = 3'd1,
    ACT_FIN_ACK = 3'd2,
    ACT_FIRST   = 3'd3,
    ACT_LAST    = 3'd4,
    ACT_ECHO    = 3'd5
  } action_e;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_ECE = 8'h40;

  localparam logic [15:0] WIN_SYN_ACK = 16'd65535;
  localparam logic [15:0] WIN_DATA    = 16'd49155;
  localparam logic [15:0] WIN_LAST    = 16'd49152;

  localparam logic [15:0] IP_LEN_ACK     = 16'd40;
  localparam logic [15:0] FRAME_LEN_SYN  = 16'd66;
  localparam logic [15:0] FRAME_LEN_ACK  = 16'd54;

  localparam logic [31:0] INIT_SEQ_RESET = 32'd1603421721;
  localparam logic [15:0] IP_ID_RESET    = 16'h8989;

  localparam int unsigned REQ_W = 256;
  localparam int unsigned RSP_W = 240;

  // received header fields, last field in the lowest bits
  typedef struct packed {
    logic [31:0] payload_head;
    logic [31:0] ack_number;
    logic [31:0] seq_number;
    logic [31:0] port_pair;
    logic [7:0]  tcp_flag_bits;
    logic [7:0]  tcp_offset_byte;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_destination;
    logic [31:0] ip_source;
    logic [7:0]  ip_version_ihl;
    logic [15:0] eth_type;
  } req_t;

  // reply descriptor, last field in the lowest bits, zero pad on top
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] reply_frame_length;
    logic [15:0] reply_ip_length;
    logic [15:0] reply_window;
    logic [31:0] reply_ack;
    logic [31:0] reply_seq;
    logic [31:0] reply_port_pair;
    logic [31:0] reply_ip_destination;
    logic [31:0] reply_ip_source;
    logic [15:0] reply_ip_id;
    logic [7:0]  reply_flag_bits;
    action_e     action;
  } rsp_t;

  // state updates requested by one classified item
  typedef struct packed {
    logic take_id;
    logic store_size;
  } upd_t;

endpackage

/* hw/rtl/ter_classify.sv */
// ter_classify: combinational header check, classification and reply build
// depends on ter_pkg
`timescale 1ns / 1ps

module ter_classify (
  input  ter_pkg::req_t req_i,
  input  logic [31:0]   init_seq_i,
  input  logic [31:0]   msg_size_i,
  input  logic [15:0]   ip_id_i,
  output ter_pkg::rsp_t rsp_o,
  output ter_pkg::upd_t upd_o
);

  logic        hdr_ok;
  logic [17:0] pay;
  logic [31:0] pay_u;
  logic        pay_zero;
  logic        pay_four;
  logic        pay_match;
  logic        is_syn;
  logic        is_ack;
  logic        is_fin;
  logic        last_msg;

  always_comb begin
    hdr_ok = (req_i.eth_type == ter_pkg::ETHERTYPE_IPV4) &&
             (req_i.ip_version_ihl[7:4] == ter_pkg::IP_VERSION_4) &&
             (req_i.ip_source != 32'd0) && (req_i.ip_destination != 32'd0) &&
             (req_i.ip_protocol == ter_pkg::PROTO_TCP);
    // payload bytes, two's complement, may go negative
    pay = {2'b00, req_i.ip_total_length}
        - {12'd0, req_i.ip_version_ihl[3:0], 2'b00}
        - {12'd0, req_i.tcp_offset_byte[7:4], 2'b00};
    pay_u     = {{14{pay[17]}}, pay};
    pay_zero  = (pay == 18'd0);
    pay_four  = (pay == 18'd4);
    pay_match = (pay_u == msg_size_i);
    is_syn    = |(req_i.tcp_flag_bits & ter_pkg::FLAG_SYN);
    is_ack    = |(req_i.tcp_flag_bits & ter_pkg::FLAG_ACK);
    is_fin    = |(req_i.tcp_flag_bits & ter_pkg::FLAG_FIN);
    last_msg  = |req_i.payload_head[15:8];
  end

  always_comb begin
    rsp_o = '0;
    upd_o = '0;
    if (hdr_ok) begin
      rsp_o.reply_ip_source      = req_i.ip_destination;
      rsp_o.reply_ip_destination = req_i.ip_source;
      rsp_o.reply_port_pair      = {req_i.port_pair[15:0], req_i.port_pair[31:16]};
      rsp_o.reply_seq            = req_i.ack_number;
      rsp_o.reply_ack            = req_i.seq_number + pay_u;
      rsp_o.reply_ip_id          = ip_id_i;
      rsp_o.reply_ip_length      = ter_pkg::IP_LEN_ACK;
      rsp_o.reply_frame_length   = ter_pkg::FRAME_LEN_ACK;
      rsp_o.reply_flag_bits      = ter_pkg::FLAG_ACK;
      upd_o.take_id              = 1'b1;
      if (is_syn) begin
        rsp_o.action             = ter_pkg::ACT_SYN_ACK;
        rsp_o.reply_flag_bits    = ter_pkg::FLAG_SYN | ter_pkg::FLAG_ACK | ter_pkg::FLAG_ECE;
        rsp_o.reply_seq          = init_seq_i;
        rsp_o.reply_ack          = req_i.seq_number + 32'd1;
        rsp_o.reply_window       = ter_pkg::WIN_SYN_ACK;
        rsp_o.reply_ip_length    = req_i.ip_total_length;
        rsp_o.reply_frame_length = ter_pkg::FRAME_LEN_SYN;
      end else if (is_ack && is_fin) begin
        // request's ip id and window are kept by the frame builder
        rsp_o.action          = ter_pkg::ACT_FIN_ACK;
        rsp_o.reply_ip_id     = 16'd0;
        rsp_o.reply_ack       = req_i.seq_number + 32'd1;
        rsp_o.reply_ip_length = req_i.ip_total_length;
        upd_o.take_id         = 1'b0;
      end else if (is_ack && pay_zero) begin
        rsp_o = '0;
        upd_o = '0;
      end else if (pay_four) begin
        rsp_o.action       = ter_pkg::ACT_FIRST;
        rsp_o.reply_window = ter_pkg::WIN_DATA;
        upd_o.store_size   = 1'b1;
      end else if (pay_match) begin
        if (last_msg) begin
          rsp_o.action          = ter_pkg::ACT_LAST;
          rsp_o.reply_flag_bits = ter_pkg::FLAG_ACK | ter_pkg::FLAG_FIN;
          rsp_o.reply_window    = ter_pkg::WIN_LAST;
        end else begin
          rsp_o.action             = ter_pkg::ACT_ECHO;
          rsp_o.reply_flag_bits    = ter_pkg::FLAG_ACK | ter_pkg::FLAG_PSH;
          rsp_o.reply_window       = ter_pkg::WIN_DATA;
          rsp_o.reply_ip_length    = ter_pkg::IP_LEN_ACK + msg_size_i[15:0];
          rsp_o.reply_frame_length = ter_pkg::FRAME_LEN_ACK + msg_size_i[15:0];
        end
      end else begin
        rsp_o = '0;
        upd_o = '0;
      end
    end
  end

endmodule

/* hw/rtl/tcp_echo_responder.sv */
// tcp_echo_responder: top level, input register, classifier, reply register
// holds the message size, ip id counter and initial sequence register
// depends on ter_pkg and ter_classify
`timescale 1ns / 1ps

// registers: a header transfer is held in the input register, then in the
//   reply register behind the classifier
// throughput: one header per cycle while the reply side keeps up, every
//   header gives exactly one reply; a dropped frame, an all-zero drop reply
// reset: asynchronous, active low; clears both valid bits, message size to 0,
//   ip id counter to 0x8989 and the initial sequence to its default
module tcp_echo_responder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // initial sequence register write
  input  logic                      cfg_we_i,
  input  logic [31:0]               cfg_wdata_i,
  // received header stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // from bit 0 up: eth_type, ip_version_ihl, ip_source, ip_destination,
  // ip_protocol, ip_total_length, tcp_offset_byte, tcp_flag_bits, port_pair,
  // seq_number, ack_number, payload_head
  input  logic [ter_pkg::REQ_W-1:0] s_axis_tdata_i,
  // reply descriptor stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // from bit 0 up: action, reply_flag_bits, reply_ip_id, reply_ip_source,
  // reply_ip_destination, reply_port_pair, reply_seq, reply_ack,
  // reply_window, reply_ip_length, reply_frame_length, 5 zero bits
  output logic [ter_pkg::RSP_W-1:0] m_axis_tdata_o
);

  // input register stage
  logic          in_valid_q;
  ter_pkg::req_t req_q;

  // reply register stage
  logic          out_valid_q;
  ter_pkg::rsp_t rsp_q;

  // block state
  logic [31:0]   init_seq_q;
  logic [31:0]   msg_size_q;
  logic [15:0]   ip_id_q;

  // classifier results
  ter_pkg::rsp_t rsp_d;
  ter_pkg::upd_t upd_d;

  logic out_free;   // reply register can take a new descriptor
  logic load;       // input stage moves into the reply register
  logic in_xfer;    // header transfer on the slave side

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign load            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = rsp_q;

  // classification sees the state left by the previous header, since state
  // updates land on the same edge that loads the reply register
  ter_classify u_classify (
    .req_i      (req_q),
    .init_seq_i (init_seq_q),
    .msg_size_i (msg_size_q),
    .ip_id_i    (ip_id_q),
    .rsp_o      (rsp_d),
    .upd_o      (upd_d)
  );

  // valid bits and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      init_seq_q  <= ter_pkg::INIT_SEQ_RESET;
      msg_size_q  <= 32'd0;
      ip_id_q     <= ter_pkg::IP_ID_RESET;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        init_seq_q <= cfg_wdata_i;
      end
      if (load && upd_d.store_size) begin
        msg_size_q <= req_q.payload_head;
      end
      if (load && upd_d.take_id) begin
        ip_id_q <= ip_id_q + 16'd1;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= ter_pkg::req_t'(s_axis_tdata_i);
    end
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  // id counter steps by one for each id-taking reply
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && upd_d.take_id |=> ip_id_q == 16'($past(ip_id_q) + 16'd1))
    else $error("ip id counter did not advance");

  // id counter holds when no id is taken
  a_id_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && upd_d.take_id) |=> $stable(ip_id_q))
    else $error("ip id counter moved without a reply");

  // message size only changes on a first-message reply
  a_size_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && upd_d.store_size) |=> $stable(msg_size_q))
    else $error("message size changed unexpectedly");

  // a held header stage only stalls while the reply register is blocked
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without back pressure");

  // a drop reply carries no descriptor content
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.action == ter_pkg::ACT_DROP |-> rsp_q == '0)
    else $error("drop reply carries nonzero fields");

endmodule
